>>> design/button_click_hold_detector_assert.svh
// ----------------------------------------------------------------------------
// Button click/hold detector - assertion macros
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BCHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bchd: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define BCHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bchd: next-cycle check failed");

`endif

>>> design/bchd_pkg.sv
// ----------------------------------------------------------------------------
// Button click/hold detector - package
// Shared types and constants for the detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

    localparam int IDX_W     = 3;
    localparam int TICK_W    = 32;
    localparam int CFG_W     = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [CFG_W-1:0] HOLD_AFTER_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] CLICK_REPEAT_RST = 16'd500;

    // register select taken from paddr[2]
    localparam logic REG_HOLD_AFTER   = 1'b0;
    localparam logic REG_CLICK_REPEAT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_HOLD  = 2'd0,
        EV_LONG  = 2'd1,
        EV_SHORT = 2'd2
    } kind_t;

    typedef struct packed {
        phase_t              phase;
        logic [TICK_W-1:0]   press_time;
        logic [TICK_W-1:0]   repeat_time;
    } btn_state_t;

    typedef struct packed {
        logic  emit;
        kind_t kind;
    } step_result_t;

endpackage

>>> design/bchd_step.sv
// ----------------------------------------------------------------------------
// Button click/hold detector - per-button step
// Next state and event for one sample of one button.
// ----------------------------------------------------------------------------
module bchd_step
    import bchd_pkg::*;
(
    input  btn_state_t        cur,
    input  logic              level,
    input  logic [TICK_W-1:0] now,
    input  logic [CFG_W-1:0]  hold_after,
    input  logic [CFG_W-1:0]  click_repeat,
    output btn_state_t        nxt,
    output step_result_t      res
);

    logic [TICK_W-1:0] since_press;
    logic [TICK_W-1:0] since_repeat;

    // differences wrap modulo 2^32
    assign since_press  = now - cur.press_time;
    assign since_repeat = now - cur.repeat_time;

    always_comb
    begin
        nxt      = cur;
        res.emit = 1'b0;
        res.kind = EV_HOLD;
        case (cur.phase)
            PH_IDLE:
            begin
                if (level)
                begin
                    nxt.press_time = now;
                    nxt.phase      = PH_PRESS;
                end
            end
            PH_PRESS:
            begin
                if (!level)
                begin
                    nxt.phase = PH_RELEASE;
                end
                else if (since_press > TICK_W'(hold_after))
                begin
                    nxt.phase       = PH_HOLD;
                    nxt.repeat_time = now;
                end
            end
            PH_HOLD:
            begin
                if (!level)
                begin
                    nxt.phase = PH_RELEASE;
                end
                else if (since_repeat > TICK_W'(click_repeat))
                begin
                    nxt.repeat_time = now;
                    res.emit        = 1'b1;
                    res.kind        = EV_HOLD;
                end
            end
            PH_RELEASE:
            begin
                // level ignored; click reported one sample after release
                res.emit       = 1'b1;
                res.kind       = (since_press >= TICK_W'(click_repeat)) ? EV_LONG : EV_SHORT;
                nxt.press_time = now;
                nxt.phase      = PH_IDLE;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> design/button_click_hold_detector.sv
// ----------------------------------------------------------------------------
// Button click/hold detector - top level
// Per-button click, long click and hold-repeat detection on tick samples.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, button_index,     | request in
//          | level, now                            |
//  out     | out_valid, out_stall, event_button,   | request out
//          | event_kind                            |
//  cfg     | psel, penable, pwrite, paddr, pwdata, | APB slave
//          | prdata, pready                        |
//
// One request per cycle sustained unless in_stall holds it; the event of an
// accepted request goes from the input register to the output register.
// Input register feeds the per-button step logic, whose event lands in
// the output register in the same cycle the button state is written.
// A request holding an event waits only while the output register is full
// and stalled; requests with no event pass straight through.
// Reset sets every button idle and the thresholds to their defaults.
// ----------------------------------------------------------------------------
module button_click_hold_detector
    import bchd_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [IDX_W-1:0]  button_index,
    input  logic              level,
    input  logic [TICK_W-1:0] now,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  event_button,
    output logic [1:0]        event_kind,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // only indices reachable through the 3-bit field need storage
    localparam int DEPTH = (NUM_BUTTONS < (1 << IDX_W)) ? NUM_BUTTONS : (1 << IDX_W);
    localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0]  hold_after_reg;
    logic [CFG_W-1:0]  click_repeat_reg;

    logic              in_vld_reg;
    logic [IDX_W-1:0]  in_idx_reg;
    logic              in_lvl_reg;
    logic [TICK_W-1:0] in_now_reg;

    logic              out_vld_reg;
    logic [IDX_W-1:0]  out_btn_reg;
    kind_t             out_kind_reg;

    phase_t            phase_reg [DEPTH];
    logic [TICK_W-1:0] press_reg [DEPTH];
    logic [TICK_W-1:0] repeat_reg [DEPTH];

    logic              idx_ok;
    logic [SEL_W-1:0]  sel;
    btn_state_t        cur_state;
    btn_state_t        nxt_state;
    step_result_t      step_res;
    logic              emit;
    logic              advance;
    logic              cfg_wr;

    assign idx_ok = 32'(in_idx_reg) < NUM_BUTTONS;
    assign sel    = SEL_W'(in_idx_reg);

    assign cur_state.phase       = phase_reg[sel];
    assign cur_state.press_time  = press_reg[sel];
    assign cur_state.repeat_time = repeat_reg[sel];

    bchd_step u_step (
        .cur          (cur_state),
        .level        (in_lvl_reg),
        .now          (in_now_reg),
        .hold_after   (hold_after_reg),
        .click_repeat (click_repeat_reg),
        .nxt          (nxt_state),
        .res          (step_res)
    );

    assign emit    = in_vld_reg && idx_ok && step_res.emit;
    assign advance = in_vld_reg && (!emit || !out_vld_reg || !out_stall);

    assign in_stall     = in_vld_reg && !advance;
    assign out_valid    = out_vld_reg;
    assign event_button = out_btn_reg;
    assign event_kind   = out_kind_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CLICK_REPEAT) ? APB_DW'(click_repeat_reg)
                                                   : APB_DW'(hold_after_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_after_reg   <= HOLD_AFTER_RST;
            click_repeat_reg <= CLICK_REPEAT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_HOLD_AFTER)
                hold_after_reg <= pwdata[CFG_W-1:0];
            else
                click_repeat_reg <= pwdata[CFG_W-1:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_idx_reg <= button_index;
            in_lvl_reg <= level;
            in_now_reg <= now;
        end
    end

    // per-button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                phase_reg[i] <= PH_IDLE;
        end
        else if (advance && idx_ok)
        begin
            phase_reg[sel] <= nxt_state.phase;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && idx_ok)
        begin
            press_reg[sel]  <= nxt_state.press_time;
            repeat_reg[sel] <= nxt_state.repeat_time;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && emit)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_btn_reg  <= in_idx_reg;
            out_kind_reg <= step_res.kind;
        end
    end

endmodule

>>> design/bchd_checker.sv
// ----------------------------------------------------------------------------
// Button click/hold detector - port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_click_hold_detector_assert.svh"

module bchd_checker
    import bchd_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] event_button,
    input logic [1:0] event_kind
);

    logic btn_ok;
    logic kind_ok;

    assign btn_ok  = 32'(event_button) < NUM_BUTTONS;
    assign kind_ok = (event_kind == EV_HOLD) || (event_kind == EV_LONG) ||
                     (event_kind == EV_SHORT);

    // an empty output register never holds back a request
    `BCHD_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !out_valid, !in_stall)

    // events only for configured buttons, and only defined kinds
    `BCHD_ASSERT_NOW(a_event_legal, clk, rst_n, out_valid, btn_ok && kind_ok)

    `BCHD_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid)

    `BCHD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(event_button) && $stable(event_kind))

endmodule

bind button_click_hold_detector bchd_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bchd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_button (event_button),
    .event_kind   (event_kind)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button click/hold detector - testbench
// Drives button samples through the request channel and predicts every
// hold-repeat, long click and short click from a per-button shadow of the
// phase machine. Thresholds are programmed over APB between phases and read
// back. Requests idle and events stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import bchd_pkg::*;

    localparam int NUM_BUTTONS    = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic [IDX_W-1:0] button;
        kind_t            kind;
    } button_event_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [IDX_W-1:0]  button_index;
    logic              level;
    logic [TICK_W-1:0] now;
    logic              out_valid;
    logic              out_stall;
    logic [IDX_W-1:0]  event_button;
    logic [1:0]        event_kind;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // shadow of the per-button state and thresholds
    phase_t            btn_phase   [NUM_BUTTONS];
    logic [TICK_W-1:0] pressed_at  [NUM_BUTTONS];
    logic [TICK_W-1:0] repeat_at   [NUM_BUTTONS];
    logic [TICK_W-1:0] last_tick   [NUM_BUTTONS];
    logic [CFG_W-1:0]  hold_after;
    logic [CFG_W-1:0]  click_repeat;

    button_event_t     events_due[$];
    int                mismatches   = 0;
    int                quiet_cycles = 0;
    int                tx_gap_max   = 0;
    int                rx_stall_max = 0;
    int                rx_wait      = 0;

    button_click_hold_detector #(.NUM_BUTTONS(NUM_BUTTONS)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_index (button_index),
        .level        (level),
        .now          (now),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_button (event_button),
        .event_kind   (event_kind),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 50)
            $display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advances the shadow for one accepted request and queues its event, if any.
    task automatic track_sample(input logic [IDX_W-1:0] b, input logic lvl,
                                input logic [TICK_W-1:0] t);
        logic [TICK_W-1:0] since_press;
        logic [TICK_W-1:0] since_repeat;
        button_event_t     ev;
        since_press  = t - pressed_at[b];
        since_repeat = t - repeat_at[b];
        last_tick[b] = t;
        ev.button    = b;
        case (btn_phase[b])
            PH_IDLE:
            begin
                if (lvl)
                begin
                    pressed_at[b] = t;
                    btn_phase[b]  = PH_PRESS;
                end
            end
            PH_PRESS:
            begin
                if (!lvl)
                    btn_phase[b] = PH_RELEASE;
                else if (since_press > {16'd0, hold_after})
                begin
                    btn_phase[b] = PH_HOLD;
                    repeat_at[b] = t;
                end
            end
            PH_HOLD:
            begin
                if (!lvl)
                    btn_phase[b] = PH_RELEASE;
                else if (since_repeat > {16'd0, click_repeat})
                begin
                    repeat_at[b] = t;
                    ev.kind      = EV_HOLD;
                    events_due.push_back(ev);
                end
            end
            default:
            begin
                // level is ignored on the sample after release
                ev.kind = (since_press >= {16'd0, click_repeat}) ? EV_LONG : EV_SHORT;
                events_due.push_back(ev);
                pressed_at[b] = t;
                btn_phase[b]  = PH_IDLE;
            end
        endcase
    endtask

    task automatic send_sample(input logic [IDX_W-1:0] b, input logic lvl,
                               input logic [TICK_W-1:0] t);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        button_index = b;
        level        = lvl;
        now          = t;
        do @(posedge clk); while (in_stall);
        track_sample(b, lvl, t);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata, input logic [CFG_W-1:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (!wr && prdata[CFG_W-1:0] !== want)
            report_mismatch($sformatf("register readback at %0d", addr),
                            prdata[CFG_W-1:0], want);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Stop sending, let every event drain and the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] hold_val,
                                  input logic [CFG_W-1:0] repeat_val);
        logic [APB_AW-1:0] hold_addr;
        logic [APB_AW-1:0] repeat_addr;
        hold_addr   = {REG_HOLD_AFTER, 2'b00};
        repeat_addr = {REG_CLICK_REPEAT, 2'b00};
        wait_idle();
        // upper bits are junk, only the low 16 bits are kept
        apb_access(1'b1, hold_addr, {16'($urandom), hold_val}, '0);
        apb_access(1'b1, repeat_addr, {16'($urandom), repeat_val}, '0);
        hold_after   = hold_val;
        click_repeat = repeat_val;
        apb_access(1'b0, hold_addr, '0, hold_after);
        apb_access(1'b0, repeat_addr, '0, click_repeat);
    endtask

    // A tick near base + thr: just below, on, just above, or anywhere.
    function automatic logic [TICK_W-1:0] near_tick(input logic [TICK_W-1:0] base,
                                                    input logic [CFG_W-1:0] thr);
        logic [TICK_W-1:0] off;
        case ($urandom_range(0, 5))
            0: off = 32'hFFFF_FFFF;
            1: off = 32'd0;
            2: off = 32'd1;
            3: off = $urandom_range(0, 64) - 32'd32;
            4: off = $urandom_range(0, 2 * thr + 2) - {16'd0, thr};
            default: off = $urandom;
        endcase
        return base + {16'd0, thr} + off;
    endfunction

    task automatic test_default_thresholds();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        apb_access(1'b0, {REG_HOLD_AFTER, 2'b00}, '0, HOLD_AFTER_RST);
        apb_access(1'b0, {REG_CLICK_REPEAT, 2'b00}, '0, CLICK_REPEAT_RST);
        send_sample(3'd0, 1'b1, 32'd0);
        send_sample(3'd0, 1'b1, 32'd1000);     // not yet past the hold threshold
        send_sample(3'd0, 1'b1, 32'd1001);
        send_sample(3'd3, 1'b0, 32'hFFFF_FFFF);
        send_sample(3'd0, 1'b1, 32'd1501);     // repeat interval not exceeded
        send_sample(3'd0, 1'b1, 32'd1502);
        send_sample(3'd0, 1'b0, 32'd1600);
        send_sample(3'd0, 1'b1, 32'd1600);     // long click after hold
        // tick wraps between press and release
        send_sample(3'd7, 1'b1, 32'hFFFF_FF00);
        send_sample(3'd7, 1'b0, 32'h0000_0010);
        send_sample(3'd7, 1'b0, 32'h0000_00F3);  // short: one tick under
        send_sample(3'd7, 1'b1, 32'h0000_00F4);
        send_sample(3'd7, 1'b0, 32'h0000_00F5);
        send_sample(3'd7, 1'b1, 32'h0000_02E8);  // long without hold, exactly on
    endtask

    task automatic test_zero_thresholds();
        set_thresholds(16'd0, 16'd0);
        tx_gap_max   = 12;
        rx_stall_max = 12;
        send_sample(3'd2, 1'b1, 32'd5);
        send_sample(3'd2, 1'b1, 32'd5);
        send_sample(3'd2, 1'b1, 32'd6);
        send_sample(3'd2, 1'b1, 32'd6);
        send_sample(3'd2, 1'b1, 32'd7);
        send_sample(3'd2, 1'b0, 32'd7);
        send_sample(3'd2, 1'b0, 32'd7);
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] hold_val,
                                    input logic [CFG_W-1:0] repeat_val,
                                    input int tx_max, input int rx_max, input int count);
        logic [IDX_W-1:0]  b;
        logic              lvl;
        logic [TICK_W-1:0] t;
        set_thresholds(hold_val, repeat_val);
        tx_gap_max   = tx_max;
        rx_stall_max = rx_max;
        repeat (count)
        begin
            b = IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
            if ($urandom_range(0, 7) == 0)
            begin
                lvl = 1'($urandom);
                t   = $urandom;
            end
            else
            begin
                case (btn_phase[b])
                    PH_IDLE:
                    begin
                        lvl = ($urandom_range(0, 3) != 0);
                        t   = ($urandom_range(0, 7) == 0) ? $urandom
                                                          : last_tick[b] + $urandom_range(0, 3);
                    end
                    PH_PRESS:
                    begin
                        lvl = ($urandom_range(0, 5) != 0);
                        t   = near_tick(pressed_at[b], hold_after);
                    end
                    PH_HOLD:
                    begin
                        lvl = ($urandom_range(0, 5) != 0);
                        t   = near_tick(repeat_at[b], click_repeat);
                    end
                    default:
                    begin
                        lvl = 1'($urandom);
                        t   = near_tick(pressed_at[b], click_repeat);
                    end
                endcase
            end
            send_sample(b, lvl, t);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(HOLD_AFTER_RST, CLICK_REPEAT_RST, 0, 0, 205);
        run_random_phase(16'd1, 16'd1, 12, 0, 205);
        run_random_phase(16'hFFFF, 16'hFFFF, 0, 12, 205);
        run_random_phase(16'd0, 16'hFFFF, 12, 12, 205);
        run_random_phase(16'hFFFF, 16'd1, 3, 3, 205);
        run_random_phase(16'($urandom), 16'($urandom), 12, 12, 205);
        run_random_phase(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)), 6, 12, 205);
    endtask

    // receiver: stall for a random number of cycles after each event
    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            out_stall = 1'b1;
            rx_wait--;
        end
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        button_event_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            rx_wait = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
            if (events_due.size() == 0)
                report_mismatch("event with nothing due, button", event_button, 0);
            else
            begin
                due = events_due.pop_front();
                if (event_button !== due.button)
                    report_mismatch("event_button", event_button, due.button);
                if (event_kind !== due.kind)
                    report_mismatch("event_kind", event_kind, due.kind);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        button_index = '0;
        level        = 1'b0;
        now          = '0;
        out_stall    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_after   = HOLD_AFTER_RST;
        click_repeat = CLICK_REPEAT_RST;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            btn_phase[i]  = PH_IDLE;
            pressed_at[i] = '0;
            repeat_at[i]  = '0;
            last_tick[i]  = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_thresholds();
        test_zero_thresholds();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
